[design/sau_pkg.sv]
`timescale 1ns / 1ps
package sau_pkg;
    typedef enum logic [2:0] {
        K_PUSH  = 3'd0,
        K_SUB   = 3'd1,
        K_DIV   = 3'd2,
        K_MUL   = 3'd3,
        K_MOD   = 3'd4,
        K_PCHAR = 3'd5
    } kind_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_DIVZERO  = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic [31:0] CHAR_LO = 32'd32;
    localparam logic [31:0] CHAR_HI = 32'd126;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        char_valid;
        logic [6:0]  char_out;
        logic [31:0] top_value;
        logic [8:0]  stack_depth;
    } res_t;
endpackage

[design/sau_ram.sv]
`timescale 1ns / 1ps
module sau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/sau_front.sv]
`timescale 1ns / 1ps
module sau_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [2:0]       kind,
    input  logic [31:0]      push_value,
    output logic             q_valid,
    input  logic             q_take,
    output sau_pkg::cmd_t    q_cmd
);
    // two-entry queue of commands between the port and the execution part
    sau_pkg::cmd_t buf_reg [2];
    logic [1:0]    cnt_reg;
    logic          rp_reg;
    logic          wp_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd   = buf_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wp_reg] <= '{kind: kind, value: push_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

[design/sau_div.sv]
`timescale 1ns / 1ps
module sau_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] quo,
    output logic [31:0] rem
);
    // restoring divider on magnitudes, one quotient bit a cycle
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [5:0]  n_reg;
    logic        busy_reg;
    logic        nq_reg;
    logic        nr_reg;
    logic [32:0] trial;

    assign trial = {r_reg, q_reg[31]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            n_reg    <= 6'd0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                n_reg    <= 6'd32;
            end
            else if (busy_reg)
            begin
                n_reg <= n_reg - 6'd1;
                if (n_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg  <= a[31] ? 32'd0 - a : a;
            d_reg  <= b[31] ? 32'd0 - b : b;
            r_reg  <= 32'd0;
            nq_reg <= a[31] ^ b[31];
            nr_reg <= a[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign quo = nq_reg ? 32'd0 - q_reg : q_reg;
    assign rem = nr_reg ? 32'd0 - r_reg : r_reg;
endmodule

[design/sau_back.sv]
`timescale 1ns / 1ps
module sau_back #(
    parameter int STACK_DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_take,
    input  sau_pkg::cmd_t q_cmd,
    output logic          r_valid,
    input  logic          r_take,
    output sau_pkg::res_t r_data
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_DIVW,
        S_RD_T,
        S_TOP,
        S_OUT
    } state_t;

    state_t        state_reg;
    sau_pkg::cmd_t cmd_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   a_reg;
    logic [31:0]   b_reg;
    logic [31:0]   top_reg;
    logic [31:0]   prod_reg;
    logic [2:0]    status_reg;
    logic          cv_reg;
    logic [6:0]    co_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic          div_start;
    logic          div_done;
    logic [31:0]   quo;
    logic [31:0]   rem;
    logic [CW-1:0] top_idx;
    logic [CW-1:0] sec_idx;
    logic          is_divop;

    assign top_idx  = cnt_reg - CW'(1);
    assign sec_idx  = cnt_reg - CW'(2);
    assign is_divop = cmd_reg.kind == sau_pkg::K_DIV || cmd_reg.kind == sau_pkg::K_MOD;

    sau_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    sau_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .a    (a_reg),
        .b    (b_reg),
        .done (div_done),
        .quo  (quo),
        .rem  (rem)
    );

    // the top is read while idle, so an arithmetic op finds it waiting in S_RD_B
    always_comb
    begin
        raddr = state_reg == S_RD_B ? sec_idx[AW-1:0] : top_idx[AW-1:0];
        we    = 1'b0;
        waddr = sec_idx[AW-1:0];
        wdata = a_reg - b_reg;
        div_start = 1'b0;
        if (state_reg == S_IDLE && q_valid && q_cmd.kind == sau_pkg::K_PUSH
            && cnt_reg < CW'(STACK_DEPTH))
        begin
            we    = 1'b1;
            waddr = cnt_reg[AW-1:0];
            wdata = q_cmd.value;
        end
        else if (state_reg == S_EXEC && is_divop && b_reg != 32'd0)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_DIVW)
        begin
            unique case (cmd_reg.kind)
                sau_pkg::K_SUB:
                begin
                    we = 1'b1;
                end
                sau_pkg::K_MUL:
                begin
                    we    = 1'b1;
                    wdata = prod_reg;
                end
                sau_pkg::K_DIV:
                begin
                    we    = div_done;
                    wdata = quo;
                end
                default:
                begin
                    we    = div_done;
                    wdata = rem;
                end
            endcase
        end
    end

    assign q_take  = state_reg == S_IDLE && q_valid;
    assign r_valid = state_reg == S_OUT;
    assign r_data  = '{status: status_reg, char_valid: cv_reg, char_out: co_reg,
                       top_value: top_reg, stack_depth: 9'(cnt_reg)};

    always_ff @(posedge clk)
    begin
        prod_reg <= a_reg * b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            cmd_reg    <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            top_reg    <= '0;
            status_reg <= sau_pkg::ST_OK;
            cv_reg     <= 1'b0;
            co_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg    <= q_cmd;
                        status_reg <= sau_pkg::ST_OK;
                        cv_reg     <= 1'b0;
                        co_reg     <= '0;
                        state_reg  <= S_RD_T;
                        priority if (q_cmd.kind == sau_pkg::K_PUSH)
                        begin
                            if (cnt_reg < CW'(STACK_DEPTH))
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                            else
                            begin
                                status_reg <= sau_pkg::ST_OVERFLOW;
                            end
                        end
                        else if (q_cmd.kind == sau_pkg::K_SUB || q_cmd.kind == sau_pkg::K_DIV
                            || q_cmd.kind == sau_pkg::K_MUL || q_cmd.kind == sau_pkg::K_MOD)
                        begin
                            if (cnt_reg < CW'(2))
                            begin
                                status_reg <= sau_pkg::ST_SHORT;
                            end
                            else
                            begin
                                state_reg <= S_RD_B;
                            end
                        end
                        else if (q_cmd.kind == sau_pkg::K_PCHAR && cnt_reg == '0)
                        begin
                            status_reg <= sau_pkg::ST_EMPTY;
                        end
                    end
                end
                S_RD_B:
                begin
                    // top entry arrives here, the second is read next
                    b_reg     <= rdata;
                    state_reg <= S_RD_A;
                end
                S_RD_A:
                begin
                    a_reg     <= rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (cmd_reg.kind == sau_pkg::K_SUB || cmd_reg.kind == sau_pkg::K_MUL
                        || div_done)
                    begin
                        cnt_reg   <= cnt_reg - CW'(1);
                        state_reg <= S_RD_T;
                    end
                    else if (b_reg == 32'd0)
                    begin
                        status_reg <= sau_pkg::ST_DIVZERO;
                        state_reg  <= S_RD_T;
                    end
                end
                S_RD_T:
                begin
                    state_reg <= S_TOP;
                end
                S_TOP:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (r_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_TOP)
            begin
                top_reg <= cnt_reg == '0 ? 32'd0 : rdata;
                if (cmd_reg.kind == sau_pkg::K_PCHAR && cnt_reg != '0)
                begin
                    if (rdata >= sau_pkg::CHAR_LO && rdata <= sau_pkg::CHAR_HI)
                    begin
                        cv_reg <= 1'b1;
                        co_reg <= rdata[6:0];
                    end
                    else
                    begin
                        status_reg <= sau_pkg::ST_RANGE;
                    end
                end
            end
        end
    end
endmodule

[design/sau_out.sv]
`timescale 1ns / 1ps
module sau_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          r_valid,
    output logic          r_take,
    input  sau_pkg::res_t r_data,
    output logic          empty,
    input  logic          pop,
    output sau_pkg::res_t o_data
);
    // one-entry result register
    logic          full_reg;
    sau_pkg::res_t data_reg;

    assign r_take = !full_reg || pop;
    assign empty  = !full_reg;
    assign o_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (r_take)
        begin
            full_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_take && r_valid)
        begin
            data_reg <= r_data;
        end
    end
endmodule

[design/stack_arithmetic_unit.sv]
`timescale 1ns / 1ps
// push, pchar, unused kinds and too-short ops go from accept through the top re-read to the result
// sub, mul and divide by zero add two stack reads and one execute step before the top re-read
// div and mod also wait in S_DIVW for the 32-step restoring divider
// one item at a time: the next is taken once its result beat has left the back end
// reset clears the entry count and the queues; stack words are not cleared
module stack_arithmetic_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         kind,
    input  logic signed [31:0] push_value,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         status,
    output logic               char_valid,
    output logic [6:0]         char_out,
    output logic signed [31:0] top_value,
    output logic [8:0]         stack_depth
);
    logic          q_valid;
    logic          q_take;
    sau_pkg::cmd_t q_cmd;
    logic          r_valid;
    logic          r_take;
    sau_pkg::res_t r_data;
    sau_pkg::res_t o_data;

    sau_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .push_value(push_value), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
    );

    sau_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
        .r_valid(r_valid), .r_take(r_take), .r_data(r_data)
    );

    sau_out u_out (
        .clk(clk), .rst_n(rst_n), .r_valid(r_valid), .r_take(r_take), .r_data(r_data),
        .empty(empty), .pop(pop), .o_data(o_data)
    );

    assign status      = o_data.status;
    assign char_valid  = o_data.char_valid;
    assign char_out    = o_data.char_out;
    assign top_value   = o_data.top_value;
    assign stack_depth = o_data.stack_depth;

    a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && char_valid |-> status == sau_pkg::ST_OK)
        else $error("char beat with error status");
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && char_valid |-> char_out >= 7'd32 && char_out <= 7'd126)
        else $error("char out of printable range");
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && stack_depth == 9'd0 && STACK_DEPTH < 512 |-> top_value == 32'sd0)
        else $error("top value on an empty stack");
endmodule

[sim/stack_arithmetic_unit_test.sv]
`timescale 1ns / 1ps
module stack_arithmetic_unit_test;
    localparam int DEPTH = 256;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] value;
        bit          hold;   // wait for all results before this beat
    } instr_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [2:0]         kind;
    logic signed [31:0] push_value;
    logic               empty;
    logic               pop;
    logic [2:0]         status;
    logic               char_valid;
    logic [6:0]         char_out;
    logic signed [31:0] top_value;
    logic [8:0]         stack_depth;

    stack_arithmetic_unit u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .kind(kind), .push_value(push_value), .empty(empty), .pop(pop),
        .status(status), .char_valid(char_valid), .char_out(char_out),
        .top_value(top_value), .stack_depth(stack_depth)
    );

    instr_t          pending_instrs[$];
    sau_pkg::res_t   expected_results[$];
    logic [31:0]     words[DEPTH];
    int              word_count;
    int              failures;
    int              cycles;
    bit              stimulus_done;
    int              burst_left;
    int              gap_left;
    int              stall_phase;

    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    // executes one instruction on the shadow stack and returns the result beat
    function automatic sau_pkg::res_t execute_instr(logic [2:0] k, logic [31:0] v);
        sau_pkg::res_t r;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   q;
        r = '0;
        r.status = sau_pkg::ST_OK;
        if (k == sau_pkg::K_PUSH)
        begin
            if (word_count >= DEPTH)
                r.status = sau_pkg::ST_OVERFLOW;
            else
            begin
                words[word_count] = v;
                word_count++;
            end
        end
        else if (k == sau_pkg::K_SUB || k == sau_pkg::K_DIV || k == sau_pkg::K_MUL
            || k == sau_pkg::K_MOD)
        begin
            if (word_count < 2)
                r.status = sau_pkg::ST_SHORT;
            else
            begin
                a = words[word_count-2];
                b = words[word_count-1];
                if ((k == sau_pkg::K_DIV || k == sau_pkg::K_MOD) && b == 0)
                    r.status = sau_pkg::ST_DIVZERO;
                else
                begin
                    case (k)
                        sau_pkg::K_SUB: q = a - b;
                        sau_pkg::K_MUL: q = a * b;
                        sau_pkg::K_DIV:
                        begin
                            q = magnitude(a) / magnitude(b);
                            if (a[31] ^ b[31]) q = -q;
                        end
                        default:
                        begin
                            q = magnitude(a) % magnitude(b);
                            if (a[31]) q = -q;
                        end
                    endcase
                    words[word_count-2] = q;
                    word_count--;
                end
            end
        end
        else if (k == sau_pkg::K_PCHAR)
        begin
            if (word_count == 0)
                r.status = sau_pkg::ST_EMPTY;
            else if (words[word_count-1] >= sau_pkg::CHAR_LO
                && words[word_count-1] <= sau_pkg::CHAR_HI)
            begin
                r.char_valid = 1'b1;
                r.char_out = words[word_count-1][6:0];
            end
            else
                r.status = sau_pkg::ST_RANGE;
        end
        r.top_value = word_count ? words[word_count-1] : 32'd0;
        r.stack_depth = word_count[8:0];
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(32, 126);
            5: return $urandom_range(0, 200);
            6: return -$urandom_range(1, 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_instr(logic [2:0] k, logic [31:0] v, bit h = 0);
        instr_t i;
        i.kind = k;
        i.value = v;
        i.hold = h;
        pending_instrs.push_back(i);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            kind <= sau_pkg::K_PUSH;
            push_value <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!(push && full))
        begin
            if (push)
                expected_results.push_back(execute_instr(kind, push_value));
            if (pending_instrs.size() == 0)
                push <= 1'b0;
            else if (pending_instrs[0].hold && (expected_results.size() != 0 || push))
                push <= 1'b0;
            else if (gap_left > 0)
            begin
                push <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                push <= 1'b1;
                kind <= pending_instrs[0].kind;
                push_value <= pending_instrs[0].value;
                void'(pending_instrs.pop_front());
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stalls on a slowly drifting duty pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[10:9] == 2'd0)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 7) < stall_phase[10:9] * 2);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sau_pkg::res_t e;
        cycles <= cycles + 1;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                failures = failures + 1;
            end
            else
            begin
                e = expected_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d got %0d", e.status, status);
                    failures = failures + 1;
                end
                if (char_valid !== e.char_valid)
                begin
                    $error("char_valid expected %0d got %0d", e.char_valid, char_valid);
                    failures = failures + 1;
                end
                if (char_out !== e.char_out)
                begin
                    $error("char_out expected %0d got %0d", e.char_out, char_out);
                    failures = failures + 1;
                end
                if (top_value !== e.top_value)
                begin
                    $error("top_value expected %0d got %0d",
                           $signed(e.top_value), top_value);
                    failures = failures + 1;
                end
                if (stack_depth !== e.stack_depth)
                begin
                    $error("stack_depth expected %0d got %0d", e.stack_depth, stack_depth);
                    failures = failures + 1;
                end
            end
        end
    end

    initial
    begin
        int n;
        int d;
        int k;
        failures = 0;
        cycles = 0;
        word_count = 0;
        // directed: errors on an empty stack first, then the corner operations
        queue_instr(sau_pkg::K_PCHAR, 0);
        queue_instr(sau_pkg::K_SUB, 0);
        queue_instr(sau_pkg::K_PUSH, 32'h8000_0000);
        queue_instr(sau_pkg::K_DIV, 0);
        queue_instr(sau_pkg::K_PUSH, 32'hffff_ffff);
        queue_instr(sau_pkg::K_DIV, 0);
        queue_instr(sau_pkg::K_PUSH, 32'h8000_0000);
        queue_instr(sau_pkg::K_PUSH, 32'hffff_ffff);
        queue_instr(sau_pkg::K_MOD, 0);
        queue_instr(sau_pkg::K_PUSH, 32'd0);
        queue_instr(sau_pkg::K_MOD, 0);
        queue_instr(sau_pkg::K_DIV, 0);
        queue_instr(sau_pkg::K_PCHAR, 0);
        queue_instr(sau_pkg::K_PUSH, 32'h7fff_ffff);
        queue_instr(sau_pkg::K_PUSH, 32'h7fff_ffff);
        queue_instr(sau_pkg::K_MUL, 32'hffff_ffff);
        queue_instr(sau_pkg::K_PUSH, -32'd7, 1);
        queue_instr(sau_pkg::K_PUSH, 32'd2);
        queue_instr(sau_pkg::K_MOD, 0);
        queue_instr(sau_pkg::K_PUSH, 32'd126);
        queue_instr(sau_pkg::K_PCHAR, 0);
        queue_instr(sau_pkg::K_PUSH, 32'd127);
        queue_instr(sau_pkg::K_PCHAR, 0);
        queue_instr(3'd6, 32'h1234_5678);
        queue_instr(3'd7, 0);
        // fill to overflow, then drain by subtraction
        for (int i = 0; i < DEPTH + 3; i++)
            queue_instr(sau_pkg::K_PUSH, $urandom, i == 0);
        queue_instr(sau_pkg::K_PCHAR, 0);
        for (int i = 0; i < DEPTH + 1; i++)
            queue_instr(sau_pkg::K_SUB, 0);
        // random: mostly arithmetic around a shallow stack
        n = 0;
        d = 1;
        while (n < 760)
        begin
            k = $urandom_range(0, 19);
            if (k < 7 || d < 2)
            begin
                queue_instr(sau_pkg::K_PUSH, random_word(), $urandom_range(0, 150) == 0);
                d++;
            end
            else if (k < 18)
            begin
                queue_instr(3'($urandom_range(sau_pkg::K_SUB, sau_pkg::K_MOD)), $urandom);
                if (d > 1) d--;
            end
            else if (k == 18)
                queue_instr(sau_pkg::K_PCHAR, $urandom);
            else
                queue_instr(3'($urandom_range(6, 7)), $urandom);
            n++;
        end
        wait (pending_instrs.size() == 0 && !push);
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done && expected_results.size() == 0);
        repeat (60) @(posedge clk);
        if (failures == 0)
            $display("stack_arithmetic_unit test passed");
        else
            $display("stack_arithmetic_unit test failed");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("stack_arithmetic_unit test failed");
        $finish;
    end
endmodule

[files.f]
design/sau_pkg.sv
design/sau_ram.sv
design/sau_front.sv
design/sau_div.sv
design/sau_back.sv
design/sau_out.sv
design/stack_arithmetic_unit.sv
sim/stack_arithmetic_unit_test.sv
